### rtl/core/fvtsm_pkg.sv
`timescale 1ns / 1ps

package fvtsm_pkg;

	localparam int NUM_VOICES   = 5;
	localparam int VOICE_W      = 3;
	localparam int PHASE_BITS   = 24;
	localparam int LENGTH_BITS  = 20;
	localparam int SINE_ENTRIES = 256;
	localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
	localparam int WAVE_W       = 16;
	localparam int GAIN_W       = 13;
	localparam int PROD_W       = WAVE_W + GAIN_W + 1;
	localparam int SUM_W        = PROD_W + 3;
	localparam int SCALED_W     = SUM_W + 14;
	localparam int MIX_SHIFT    = 27;
	localparam int LFSR_W       = 15;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = GAIN_W;

	localparam int IN_FIELDS_W  = VOICE_W + PHASE_BITS + LENGTH_BITS;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = WAVE_W + 1 + NUM_VOICES;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic signed [WAVE_W-1:0] WAVE_MAX = 16'sh7fff;
	localparam logic signed [WAVE_W-1:0] WAVE_MIN = 16'sh8000;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_NOTE = 1'b1
	} op_e;

	typedef enum logic [VOICE_W-1:0] {
		VOICE_SINE,
		VOICE_SQUARE,
		VOICE_SAW,
		VOICE_TRIANGLE,
		VOICE_NOISE
	} voice_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VOL_SINE,
		CFG_VOL_SQUARE,
		CFG_VOL_SAW,
		CFG_VOL_TRIANGLE,
		CFG_VOL_NOISE,
		CFG_MUTE
	} cfg_idx_e;

	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		prod_t [NUM_VOICES-1:0]  prod;
		logic                    accepted;
		logic [NUM_VOICES-1:0]   active;
	} mix_item_t;

	typedef logic [SINE_ENTRIES-1:0][WAVE_W-1:0] sine_rom_t;

	// q30 taylor series, evaluated at elaboration only
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] turn;
		logic [63:0] u;
		logic [63:0] theta;
		logic [63:0] theta2;
		logic [63:0] term;
		logic [63:0] prod;
		logic [63:0] mag;
		logic [1:0]  quad;
		longint      sum;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			turn = 64'(k) << (32 - SINE_IDX_W);
			quad = turn[31:30];
			u = {34'd0, turn[29:0]};
			if (quad[0]) begin
				u = (64'd1 << 30) - u;
			end
			theta  = (u * 64'd1686629713) >> 30;
			theta2 = (theta * theta) >> 30;
			term   = theta;
			sum    = longint'(theta);
			for (int j = 0; j < 7; j++) begin
				prod = (term * theta2) >> 30;
				case (j)
					0: term = prod / 64'd6;
					1: term = prod / 64'd20;
					2: term = prod / 64'd42;
					3: term = prod / 64'd72;
					4: term = prod / 64'd110;
					5: term = prod / 64'd156;
					default: term = prod / 64'd210;
				endcase
				if ((j % 2) == 0) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > (longint'(1) << 30)) begin
				sum = longint'(1) << 30;
			end
			mag = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
			if (quad[1]) begin
				rom[k] = WAVE_W'(-mag);
			end else begin
				rom[k] = WAVE_W'(mag);
			end
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### rtl/core/fvtsm_voice_bank.sv
`timescale 1ns / 1ps

module fvtsm_voice_bank
	import fvtsm_pkg::*;
(
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              op,
	input  logic [VOICE_W-1:0]                voice,
	input  logic [PHASE_BITS-1:0]             step,
	input  logic [LENGTH_BITS-1:0]            len,
	input  logic [NUM_VOICES-1:0][GAIN_W-1:0] gain,
	input  logic [NUM_VOICES-1:0]             mute,
	output mix_item_t                         item
);

	logic [NUM_VOICES-1:0][PHASE_BITS-1:0]  phase_q, phase_d;
	logic [NUM_VOICES-1:0][PHASE_BITS-1:0]  step_q, step_d;
	logic [NUM_VOICES-1:0][LENGTH_BITS-1:0] rem_q, rem_d;
	logic [NUM_VOICES-1:0]                  active_q, active_d;
	logic [NUM_VOICES-1:0]                  qv_q, qv_d;
	logic [NUM_VOICES-1:0][PHASE_BITS-1:0]  qstep_q;
	logic [NUM_VOICES-1:0][LENGTH_BITS-1:0] qlen_q;
	logic [NUM_VOICES-1:0]                  qload;
	logic [LFSR_W-1:0]                      lfsr_q, lfsr_d;
	logic signed [WAVE_W-1:0]               wave [NUM_VOICES];
	logic                                   is_tick;
	logic                                   accepted;

	assign is_tick = (op == OP_TICK);

	always_comb begin
		logic [WAVE_W-1:0] u;
		logic signed [17:0] q;
		logic signed [17:0] d;
		logic signed [17:0] t;
		wave[VOICE_SINE] = $signed(SINE_ROM[phase_q[VOICE_SINE][PHASE_BITS-1 -: SINE_IDX_W]]);

		u = phase_q[VOICE_SQUARE][PHASE_BITS-1 -: WAVE_W];
		wave[VOICE_SQUARE] = (u[WAVE_W-1 -: 2] == 2'b00) ? WAVE_MAX : WAVE_MIN;

		u = phase_q[VOICE_SAW][PHASE_BITS-1 -: WAVE_W];
		wave[VOICE_SAW] = $signed({~u[WAVE_W-1], u[WAVE_W-2:0]});

		u = phase_q[VOICE_TRIANGLE][PHASE_BITS-1 -: WAVE_W];
		q = $signed({2'b00, u}) - 18'sd16384;
		if (q < 0) begin
			d = -q;
		end else if (q < 18'sd32768) begin
			d = q;
		end else begin
			d = 18'sd65536 - q;
		end
		t = 18'sd32768 - (d <<< 1);
		wave[VOICE_TRIANGLE] = (t > 18'sd32767) ? WAVE_MAX : t[WAVE_W-1:0];

		// the value comes from bit 0 after the shift
		wave[VOICE_NOISE] = lfsr_q[1] ? WAVE_MAX : WAVE_MIN;
	end

	always_comb begin
		logic hit;
		phase_d  = phase_q;
		step_d   = step_q;
		rem_d    = rem_q;
		active_d = active_q;
		qv_d     = qv_q;
		qload    = '0;
		accepted = 1'b0;
		for (int v = 0; v < NUM_VOICES; v++) begin
			hit = (voice == VOICE_W'(v));
			if (is_tick) begin
				if (active_q[v]) begin
					phase_d[v] = phase_q[v] + step_q[v];
					if (rem_q[v] <= LENGTH_BITS'(1)) begin
						if (qv_q[v]) begin
							step_d[v] = qstep_q[v];
							rem_d[v]  = qlen_q[v];
							qv_d[v]   = 1'b0;
						end else begin
							active_d[v] = 1'b0;
							rem_d[v]    = '0;
						end
					end else begin
						rem_d[v] = rem_q[v] - LENGTH_BITS'(1);
					end
				end
			end else if (hit) begin
				if (!active_q[v]) begin
					step_d[v]   = step;
					rem_d[v]    = len;
					active_d[v] = 1'b1;
					accepted    = 1'b1;
				end else if (!qv_q[v]) begin
					qload[v] = 1'b1;
					qv_d[v]  = 1'b1;
					accepted = 1'b1;
				end
			end
		end
	end

	assign lfsr_d = (is_tick && active_q[VOICE_NOISE])
		? {lfsr_q[0] ^ lfsr_q[1], lfsr_q[LFSR_W-1:1]} : lfsr_q;

	always_comb begin
		for (int v = 0; v < NUM_VOICES; v++) begin
			if (is_tick && active_q[v] && !mute[v]) begin
				item.prod[v] = prod_t'(wave[v]) * prod_t'($signed({1'b0, gain[v]}));
			end else begin
				item.prod[v] = '0;
			end
		end
		item.accepted = accepted;
		item.active   = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			step_q   <= '0;
			rem_q    <= '0;
			active_q <= '0;
			qv_q     <= '0;
			lfsr_q   <= LFSR_W'(1);
		end else if (advance) begin
			phase_q  <= phase_d;
			step_q   <= step_d;
			rem_q    <= rem_d;
			active_q <= active_d;
			qv_q     <= qv_d;
			lfsr_q   <= lfsr_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < NUM_VOICES; v++) begin
			if (advance && qload[v]) begin
				qstep_q[v] <= step;
				qlen_q[v]  <= len;
			end
		end
	end

endmodule

### rtl/core/fvtsm_mixer.sv
`timescale 1ns / 1ps

module fvtsm_mixer
	import fvtsm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  mix_item_t                in_item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WAVE_W-1:0] out_sample,
	output logic                     out_accepted,
	output logic [NUM_VOICES-1:0]    out_active
);

	mix_item_t                 item_s2;
	logic                      v_s2;
	logic signed [SUM_W-1:0]   sum_s3;
	logic                      acc_s3;
	logic [NUM_VOICES-1:0]     active_s3;
	logic                      v_s3;
	logic signed [WAVE_W-1:0]  sample_q;
	logic                      acc_q;
	logic [NUM_VOICES-1:0]     active_q;
	logic                      valid_q;
	logic                      ready_out, ready_s3, ready_s2;
	logic signed [SUM_W-1:0]   sum;
	logic signed [SCALED_W-1:0] scaled;
	logic signed [SCALED_W-MIX_SHIFT-1:0] shifted;
	logic signed [WAVE_W-1:0]  sample_sat;

	assign ready_out = !valid_q || out_ready;
	assign ready_s3  = !v_s3 || ready_out;
	assign ready_s2  = !v_s2 || ready_s3;
	assign in_ready  = ready_s2;

	always_comb begin
		sum = '0;
		for (int v = 0; v < NUM_VOICES; v++) begin
			sum = sum + SUM_W'($signed(item_s2.prod[v]));
		end
	end

	// x8000 as x8192 - x128 - x64
	always_comb begin
		scaled = (SCALED_W'(sum_s3) <<< 13) - (SCALED_W'(sum_s3) <<< 7)
			- (SCALED_W'(sum_s3) <<< 6);
		shifted = scaled[SCALED_W-1:MIX_SHIFT];
		if (shifted > $signed((SCALED_W-MIX_SHIFT)'(WAVE_MAX))) begin
			sample_sat = WAVE_MAX;
		end else if (shifted < (SCALED_W-MIX_SHIFT)'(WAVE_MIN)) begin
			sample_sat = WAVE_MIN;
		end else begin
			sample_sat = shifted[WAVE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (ready_s2) begin
				v_s2 <= in_valid;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
			if (ready_out) begin
				valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s2) begin
			item_s2 <= in_item;
		end
		if (v_s2 && ready_s3) begin
			sum_s3    <= sum;
			acc_s3    <= item_s2.accepted;
			active_s3 <= item_s2.active;
		end
		if (v_s3 && ready_out) begin
			sample_q <= sample_sat;
			acc_q    <= acc_s3;
			active_q <= active_s3;
		end
	end

	assign out_valid    = valid_q;
	assign out_sample   = sample_q;
	assign out_accepted = acc_q;
	assign out_active   = active_q;

endmodule

### rtl/core/five_voice_tone_synth_mixer.sv
`timescale 1ns / 1ps
// throughput: one beat per cycle while m_axis_tready does not stall the pipeline; voice state updates on each beat
// pipeline: input register, voice update and gain multiply, mix sum, scale and saturate
// reset: arst_n clears voices, queues, volumes and mute, and sets the noise lfsr to 1

module five_voice_tone_synth_mixer
	import fvtsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // voice, phase_step, length_samples
	input  logic                  s_axis_tuser,  // op
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // sample_out, accepted, active_mask
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [NUM_VOICES-1:0][GAIN_W-1:0] volume_q;
	logic [NUM_VOICES-1:0]             mute_q;
	logic                              valid_s1;
	logic                              op_s1;
	logic [VOICE_W-1:0]                voice_s1;
	logic [PHASE_BITS-1:0]             step_s1;
	logic [LENGTH_BITS-1:0]            len_s1;
	logic                              ready_s1;
	logic                              mix_ready;
	logic                              advance;
	mix_item_t                         item;
	logic signed [WAVE_W-1:0]          sample;
	logic                              accepted;
	logic [NUM_VOICES-1:0]             active;

	assign ready_s1      = !valid_s1 || mix_ready;
	assign advance       = valid_s1 && mix_ready;
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= '0;
			mute_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_VOL_SINE:     volume_q[VOICE_SINE]     <= cfg_wdata;
				CFG_VOL_SQUARE:   volume_q[VOICE_SQUARE]   <= cfg_wdata;
				CFG_VOL_SAW:      volume_q[VOICE_SAW]      <= cfg_wdata;
				CFG_VOL_TRIANGLE: volume_q[VOICE_TRIANGLE] <= cfg_wdata;
				CFG_VOL_NOISE:    volume_q[VOICE_NOISE]    <= cfg_wdata;
				CFG_MUTE:         mute_q <= cfg_wdata[NUM_VOICES-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && ready_s1) begin
			op_s1    <= s_axis_tuser;
			voice_s1 <= s_axis_tdata[VOICE_W-1:0];
			step_s1  <= s_axis_tdata[VOICE_W +: PHASE_BITS];
			len_s1   <= s_axis_tdata[VOICE_W+PHASE_BITS +: LENGTH_BITS];
		end
	end

	fvtsm_voice_bank u_voices (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.op      (op_s1),
		.voice   (voice_s1),
		.step    (step_s1),
		.len     (len_s1),
		.gain    (volume_q),
		.mute    (mute_q),
		.item    (item)
	);

	fvtsm_mixer u_mixer (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (valid_s1),
		.in_ready     (mix_ready),
		.in_item      (item),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_sample   (sample),
		.out_accepted (accepted),
		.out_active   (active)
	);

	assign m_axis_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), active, accepted, sample};

endmodule

### rtl/core/fvtsm_checker.sv
`timescale 1ns / 1ps

module fvtsm_checker
	import fvtsm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int ACC_BIT = WAVE_W;
	localparam int ACT_LSB = WAVE_W + 1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	a_note_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[ACC_BIT] |-> m_axis_tdata[WAVE_W-1:0] == '0)
		else $error("accepted note carries a nonzero sample");

	a_note_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[ACC_BIT]
		|-> m_axis_tdata[ACT_LSB +: NUM_VOICES] != '0)
		else $error("accepted note with no voice sounding");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled with no output backpressure");

endmodule

bind five_voice_tone_synth_mixer fvtsm_checker u_fvtsm_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import fvtsm_pkg::*;

	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int MIX_SCALE    = 8000;
	localparam int MIX_SHR      = 27;

	localparam logic [63:0]           PI_HALF_Q30  = 64'd1686629713;
	localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED   = 3'd6;
	localparam logic [VOICE_W-1:0]    VOICE_OOR_LO = 3'd5;
	localparam logic [VOICE_W-1:0]    VOICE_OOR_HI = 3'd7;
	localparam logic [GAIN_W-1:0]     GAIN_UNITY   = 13'd4096;
	localparam logic [GAIN_W-1:0]     GAIN_MAX     = '1;
	localparam logic [GAIN_W-1:0]     GAIN_ZERO    = '0;
	localparam logic [NUM_VOICES-1:0] MUTE_NONE    = '0;
	localparam logic [NUM_VOICES-1:0] MUTE_ALL     = '1;

	typedef struct packed {
		logic signed [WAVE_W-1:0] sample;
		logic                     accepted;
		logic [NUM_VOICES-1:0]    active;
	} mix_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // voice, phase_step, length_samples
	logic                  s_axis_tuser = 1'b0;  // op
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // sample_out, accepted, active_mask
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// voice state mirror
	logic [PHASE_BITS-1:0]  phase_acc [NUM_VOICES];
	logic [PHASE_BITS-1:0]  cur_step [NUM_VOICES];
	logic [LENGTH_BITS-1:0] left [NUM_VOICES];
	logic [PHASE_BITS-1:0]  next_step [NUM_VOICES];
	logic [LENGTH_BITS-1:0] next_len [NUM_VOICES];
	logic [NUM_VOICES-1:0]  sounding;
	logic [NUM_VOICES-1:0]  pending;
	logic [LFSR_W-1:0]      lfsr;
	logic [GAIN_W-1:0]      gain [NUM_VOICES];
	logic [NUM_VOICES-1:0]  mute;
	int                     sine_tab [SINE_ENTRIES];

	mix_out_t expected_mix [$];
	mix_out_t want;

	int errors = 0;
	int beats_checked = 0;
	int ticks_sent = 0;
	int notes_taken = 0;
	int notes_refused = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	five_voice_tone_synth_mixer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// q30 odd power series over one quadrant, mirrored to the full turn
	function automatic int sine_entry(int k);
		logic [63:0] turn;
		logic [63:0] frac;
		logic [63:0] theta;
		logic [63:0] theta2;
		logic [63:0] term;
		logic [1:0]  quad;
		longint      sum;
		int          mag;
		turn = (64'(k) << 32) / SINE_ENTRIES;
		quad = turn[31:30];
		frac = turn & ((64'd1 << 30) - 64'd1);
		if (quad[0]) begin
			frac = (64'd1 << 30) - frac;
		end
		theta = (frac * PI_HALF_Q30) >> 30;
		theta2 = (theta * theta) >> 30;
		term = theta;
		sum = longint'(theta);
		for (int n = 3; n <= 15; n += 2) begin
			term = ((term * theta2) >> 30) / 64'((n - 1) * n);
			if ((n % 4) == 3) begin
				sum -= longint'(term);
			end else begin
				sum += longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (longint'(1) << 30)) begin
			sum = longint'(1) << 30;
		end
		mag = int'((64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
		return quad[1] ? -mag : mag;
	endfunction

	function automatic int voice_wave(int v, logic [PHASE_BITS-1:0] ph);
		logic [15:0] u;
		int          q;
		int          d;
		int          t;
		u = ph[PHASE_BITS-1 -: 16];
		case (voice_e'(v))
			VOICE_SINE: begin
				return sine_tab[ph[PHASE_BITS-1 -: SINE_IDX_W]];
			end
			VOICE_SQUARE: begin
				return (u < 16'd16384) ? 32767 : -32768;
			end
			VOICE_SAW: begin
				return int'(u) - 32768;
			end
			VOICE_TRIANGLE: begin
				q = int'(u) - 16384;
				d = (q < 0) ? -q : ((q < 32768) ? q : 65536 - q);
				t = 32768 - 2 * d;
				return (t > 32767) ? 32767 : t;
			end
			default: begin
				lfsr = {lfsr[0] ^ lfsr[1], lfsr[LFSR_W-1:1]};
				return lfsr[0] ? 32767 : -32768;
			end
		endcase
	endfunction

	function automatic mix_out_t predict_mix(op_e op, logic [VOICE_W-1:0] voice,
			logic [PHASE_BITS-1:0] step, logic [LENGTH_BITS-1:0] len);
		mix_out_t r;
		longint   acc;
		longint   scaled;
		int       w;
		r = '0;
		if (op == OP_NOTE) begin
			if (voice < NUM_VOICES) begin
				if (!sounding[voice]) begin
					cur_step[voice] = step;
					left[voice] = len;
					sounding[voice] = 1'b1;
					r.accepted = 1'b1;
				end else if (!pending[voice]) begin
					next_step[voice] = step;
					next_len[voice] = len;
					pending[voice] = 1'b1;
					r.accepted = 1'b1;
				end
			end
		end else begin
			acc = 0;
			for (int v = 0; v < NUM_VOICES; v++) begin
				if (sounding[v]) begin
					w = voice_wave(v, phase_acc[v]);
					if (!mute[v]) begin
						acc += longint'(w) * longint'(gain[v]);
					end
					phase_acc[v] = phase_acc[v] + cur_step[v];
					if (left[v] <= 1) begin
						if (pending[v]) begin
							cur_step[v] = next_step[v];
							left[v] = next_len[v];
							pending[v] = 1'b0;
						end else begin
							sounding[v] = 1'b0;
							left[v] = '0;
						end
					end else begin
						left[v] = left[v] - 1'b1;
					end
				end
			end
			scaled = (acc * MIX_SCALE) >>> MIX_SHR;
			if (scaled > 32767) begin
				scaled = 32767;
			end
			if (scaled < -32768) begin
				scaled = -32768;
			end
			r.sample = scaled[WAVE_W-1:0];
		end
		r.active = sounding;
		return r;
	endfunction

	// output side: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_mix.size() == 0) begin
				$display("%0t: beat with nothing expected, got %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = expected_mix.pop_front();
				beats_checked++;
				if (m_axis_tdata[WAVE_W-1:0] !== want.sample) begin
					$display("%0t: sample_out expected %0d got %0d", $time,
						want.sample, $signed(m_axis_tdata[WAVE_W-1:0]));
					errors++;
				end
				if (m_axis_tdata[WAVE_W] !== want.accepted) begin
					$display("%0t: accepted expected %0b got %0b", $time,
						want.accepted, m_axis_tdata[WAVE_W]);
					errors++;
				end
				if (m_axis_tdata[WAVE_W+1 +: NUM_VOICES] !== want.active) begin
					$display("%0t: active_mask expected %b got %b", $time,
						want.active, m_axis_tdata[WAVE_W+1 +: NUM_VOICES]);
					errors++;
				end
			end
		end
	end

	task automatic send_beat(op_e op, logic [VOICE_W-1:0] voice,
			logic [PHASE_BITS-1:0] step, logic [LENGTH_BITS-1:0] len);
		mix_out_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= IN_DATA_W'({len, step, voice});
		do @(posedge clk); while (!s_axis_tready);
		r = predict_mix(op, voice, step, len);
		expected_mix.push_back(r);
		if (op == OP_TICK) begin
			ticks_sent++;
		end else if (r.accepted) begin
			notes_taken++;
		end else begin
			notes_refused++;
		end
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_mix.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx <= CFG_VOL_NOISE) begin
			gain[idx] = data;
		end else if (idx == CFG_MUTE) begin
			mute = data[NUM_VOICES-1:0];
		end
	endtask

	task automatic write_all_gains(logic [GAIN_W-1:0] g, logic [NUM_VOICES-1:0] m);
		for (int v = 0; v < NUM_VOICES; v++) begin
			write_reg(cfg_idx_e'(v), g);
		end
		write_reg(CFG_MUTE, CFG_DATA_W'(m));
	endtask

	task automatic send_tick();
		send_beat(OP_TICK, VOICE_SINE, '0, '0);
	endtask

	task automatic send_random_item();
		op_e                    op;
		logic [VOICE_W-1:0]     voice;
		logic [PHASE_BITS-1:0]  step;
		logic [LENGTH_BITS-1:0] len;
		op = ($urandom_range(99) < 55) ? OP_TICK : OP_NOTE;
		if ($urandom_range(9) == 0) begin
			voice = VOICE_W'($urandom_range(VOICE_OOR_HI, VOICE_OOR_LO));
		end else begin
			voice = VOICE_W'($urandom_range(NUM_VOICES - 1));
		end
		step = PHASE_BITS'($urandom);
		if ($urandom_range(99) < 80) begin
			len = LENGTH_BITS'($urandom_range(12));
		end else begin
			len = LENGTH_BITS'($urandom_range(300));
		end
		send_beat(op, voice, step, len);
	endtask

	task automatic test_directed_notes();
		send_tick();
		wait_idle();
		write_all_gains(GAIN_UNITY, MUTE_NONE);
		send_beat(OP_NOTE, VOICE_SINE, 24'h010000, 20'd4);
		send_beat(OP_NOTE, VOICE_SQUARE, 24'h100000, 20'd0);
		send_beat(OP_NOTE, VOICE_SAW, 24'hffffff, 20'd2);
		send_beat(OP_NOTE, VOICE_TRIANGLE, 24'h000000, 20'd1);
		send_beat(OP_NOTE, VOICE_NOISE, 24'h000001, 20'd3);
		// queue behind a sounding voice, then overflow it
		send_beat(OP_NOTE, VOICE_SAW, 24'h400000, 20'd2);
		send_beat(OP_NOTE, VOICE_SAW, 24'h123456, 20'd5);
		send_beat(OP_NOTE, VOICE_OOR_LO, 24'h080000, 20'd3);
		send_beat(OP_NOTE, VOICE_OOR_HI, 24'h080000, 20'd3);
		repeat (6) send_tick();
		send_beat(OP_NOTE, VOICE_SQUARE, 24'h200000, 20'd5);
		send_beat(OP_NOTE, VOICE_TRIANGLE, 24'h0c0000, 20'd3);
		send_beat(OP_NOTE, VOICE_TRIANGLE, 24'h333333, 20'd2);
		repeat (6) send_tick();
	endtask

	task automatic test_random_mix();
		for (int s = 0; s < 4; s++) begin
			wait_idle();
			case (s)
				0: write_all_gains(GAIN_MAX, MUTE_NONE);
				1: write_all_gains(GAIN_ZERO, MUTE_NONE);
				2: write_all_gains(GAIN_UNITY, MUTE_ALL);
				default: begin
					for (int v = 0; v < NUM_VOICES; v++) begin
						write_reg(cfg_idx_e'(v), CFG_DATA_W'($urandom));
					end
					write_reg(CFG_MUTE, CFG_DATA_W'($urandom));
				end
			endcase
			repeat (40) send_random_item();
		end
	endtask

	task automatic test_unused_register();
		wait_idle();
		write_all_gains(GAIN_UNITY, NUM_VOICES'($urandom));
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		repeat (20) send_random_item();
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_reqs <= hold_reqs + 1;
		repeat (40) send_random_item();
	endtask

	task automatic test_long_notes();
		wait_idle();
		write_all_gains(GAIN_UNITY, MUTE_NONE);
		for (int i = 0; i < 24; i++) begin
			if (i % 3 == 2) begin
				send_tick();
			end else begin
				send_beat(OP_NOTE, VOICE_W'($urandom_range(NUM_VOICES - 1)),
					PHASE_BITS'($urandom), LENGTH_BITS'($urandom));
			end
		end
		send_beat(OP_NOTE, VOICE_SINE, 24'hffffff, 20'hfffff);
		repeat (4) send_tick();
	endtask

	initial begin
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			sine_tab[k] = sine_entry(k);
		end
		for (int v = 0; v < NUM_VOICES; v++) begin
			phase_acc[v] = '0;
			cur_step[v] = '0;
			left[v] = '0;
			next_step[v] = '0;
			next_len[v] = '0;
			gain[v] = '0;
		end
		sounding = '0;
		pending = '0;
		mute = '0;
		lfsr = LFSR_W'(1);
		send_idle_pct = 13;
		recv_idle_pct = 49;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_notes();
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 13 : ((p == 1) ? 49 : 0);
			recv_idle_pct = (p == 0) ? 49 : ((p == 1) ? 13 : 0);
			test_random_mix();
		end
		test_unused_register();
		test_output_backpressure();
		test_long_notes();
		wait_idle();
		$display("run covered %0d ticks, %0d notes taken and %0d notes refused",
			ticks_sent, notes_taken, notes_refused);
		$display("%0d output beats checked across gain, mute and stall settings",
			beats_checked);
		if (errors == 0) begin
			$display("[five_voice_tone_synth_mixer] OK");
		end else begin
			$display("[five_voice_tone_synth_mixer] ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[five_voice_tone_synth_mixer] ERROR");
		$finish;
	end

endmodule
